>>> rtl/core/range_and_longest_run_search_macros.svh
`ifndef RANGE_AND_LONGEST_RUN_SEARCH_MACROS_SVH
`define RANGE_AND_LONGEST_RUN_SEARCH_MACROS_SVH

// same-cycle implication on the block clock, off during reset
`define RARS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the block clock, off during reset
`define RARS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/rars_pkg.sv
package rars_pkg;

   localparam int VALUE_W = 31;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   localparam logic [VALUE_W-1:0] ALL_ONES    = 31'h7fff_ffff;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] threshold;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] end_position;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_WLEAF,
      CMD_WUP,
      CMD_QINIT,
      CMD_SHIFT,
      CMD_TAKE,
      CMD_DOWN,
      CMD_RESP_MISS,
      CMD_RESP_ALL,
      CMD_RESP_CUR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      sibling;
   } dp_cmd_type;

   typedef struct packed {
      logic is_query;
      logic write_ok;
      logic out_of_range;
      logic cur_odd;
      logic cur_root;
      logic cur_pow2;
      logic cur_at_leaf;
      logic pred;
      logic clear_last;
   } dp_status_type;

endpackage

>>> rtl/core/rars_ram.sv
module rars_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rars_ctrl.sv
module rars_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rars_pkg::dp_status_type status,
   output rars_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import rars_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_WUP,
      S_QEVEN,
      S_QPOW,
      S_DDOWN,
      S_DTEST
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = CMD_NOP;
      cmd.sibling = 1'b0;
      strobe_in   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = CMD_CLEAR;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.is_query) begin
               if (status.out_of_range) begin
                  cmd.op    = CMD_RESP_MISS;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cmd.op   = CMD_QINIT;
                  state_in = S_QEVEN;
               end
            end else if (status.write_ok) begin
               cmd.op      = CMD_WLEAF;
               cmd.sibling = 1'b1;
               state_in    = S_WUP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WUP: begin
            if (status.cur_root) begin
               state_in = S_IDLE;
            end else begin
               cmd.op      = CMD_WUP;
               cmd.sibling = 1'b1;
            end
         end
         S_QEVEN: begin
            if (!status.cur_odd) begin
               cmd.op = CMD_SHIFT;
            end else if (status.pred) begin
               cmd.op   = CMD_TAKE;
               state_in = S_QPOW;
            end else begin
               state_in = S_DDOWN;
            end
         end
         S_QPOW: begin
            if (status.cur_pow2) begin
               cmd.op    = CMD_RESP_ALL;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_QEVEN;
            end
         end
         S_DDOWN: begin
            if (status.cur_at_leaf) begin
               cmd.op    = CMD_RESP_CUR;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cmd.op   = CMD_DOWN;
               state_in = S_DTEST;
            end
         end
         S_DTEST: begin
            if (status.pred) begin
               cmd.op = CMD_TAKE;
            end
            state_in = S_DDOWN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

>>> rtl/core/rars_dp.sv
module rars_dp #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rars_pkg::req_type             req_data,
   input  logic                          csr_we,
   input  logic [rars_pkg::COUNT_W-1:0]  csr_data,
   input  rars_pkg::dp_cmd_type          cmd,
   output rars_pkg::dp_status_type       status,
   output rars_pkg::rsp_type             rsp_data
);
   import rars_pkg::*;

   localparam int LEVELS = $clog2(MAX_ELEMENTS);
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODE_W = LEVELS + 1;
   localparam int CUR_W  = LEVELS + 2;
   localparam int DEPTH  = 2 * LEAVES;
   localparam int CMP_W  = (NODE_W > COUNT_W) ? NODE_W : COUNT_W;

   localparam logic [CMP_W-1:0] MAX_C    = CMP_W'(MAX_ELEMENTS);
   localparam logic [CUR_W-1:0] LEAF_CUR = CUR_W'(LEAVES);

   op_type             op_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] thr_ff;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [CUR_W-1:0]   cur_ff, cur_in;
   logic [NODE_W-1:0]  clr_ff;
   logic [COUNT_W-1:0] count_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [NODE_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [NODE_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data;

   logic [VALUE_W-1:0] and_val;
   logic [CUR_W-1:0]   leaf_cur;
   logic [CMP_W-1:0]   idx_ext, count_ext, count_eff, res_ext, end_ext;
   logic               res_found;

   rars_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign and_val   = acc_ff & rd_data;
   assign leaf_cur  = LEAF_CUR + CUR_W'(idx_ff);
   assign idx_ext   = CMP_W'(idx_ff);
   assign count_ext = CMP_W'(count_ff);
   assign count_eff = (count_ext > MAX_C) ? MAX_C : count_ext;

   always_comb begin
      status.is_query     = (op_ff == OP_QUERY);
      status.write_ok     = (idx_ext < MAX_C);
      status.out_of_range = (idx_ext >= count_eff);
      status.cur_odd      = cur_ff[0];
      status.cur_root     = (cur_ff == CUR_W'(1));
      status.cur_pow2     = ((cur_ff & (cur_ff - CUR_W'(1))) == '0);
      status.cur_at_leaf  = (cur_ff >= LEAF_CUR);
      status.pred         = (and_val >= thr_ff);
      status.clear_last   = (&clr_ff);
   end

   always_comb begin
      cur_in = cur_ff;
      acc_in = acc_ff;
      case (cmd.op)
         CMD_WLEAF: begin
            cur_in = leaf_cur;
            acc_in = value_ff;
         end
         CMD_QINIT: begin
            cur_in = leaf_cur;
            acc_in = ALL_ONES;
         end
         CMD_WUP: begin
            cur_in = cur_ff >> 1;
            acc_in = and_val;
         end
         CMD_SHIFT: begin
            cur_in = cur_ff >> 1;
         end
         CMD_TAKE: begin
            cur_in = cur_ff + CUR_W'(1);
            acc_in = and_val;
         end
         CMD_DOWN: begin
            cur_in = cur_ff << 1;
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   assign rd_addr = cur_in[NODE_W-1:0] ^ NODE_W'(cmd.sibling);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = ALL_ONES;
      case (cmd.op)
         CMD_CLEAR: begin
            wr_en = 1'b1;
         end
         CMD_WLEAF: begin
            wr_en   = 1'b1;
            wr_addr = leaf_cur[NODE_W-1:0];
            wr_data = value_ff;
         end
         CMD_WUP: begin
            wr_en   = 1'b1;
            wr_addr = cur_in[NODE_W-1:0];
            wr_data = and_val;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.op == CMD_RESP_ALL) begin
         res_ext = CMP_W'(LEAVES);
      end else begin
         res_ext = CMP_W'(cur_ff - LEAF_CUR);
      end
      res_found = (res_ext > idx_ext);
      end_ext   = (res_ext < count_eff) ? res_ext : count_eff;
      rsp_in    = rsp_ff;
      case (cmd.op)
         CMD_RESP_MISS: begin
            rsp_in.found        = 1'b0;
            rsp_in.end_position = '0;
         end
         CMD_RESP_ALL, CMD_RESP_CUR: begin
            rsp_in.found        = res_found;
            rsp_in.end_position = res_found ? end_ext[COUNT_W-1:0] : '0;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         clr_ff   <= '0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_data;
         end
         if (cmd.op == CMD_CLEAR) begin
            clr_ff <= clr_ff + NODE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_LOAD) begin
         op_ff    <= req_data.op;
         idx_ff   <= req_data.index;
         value_ff <= req_data.value;
         thr_ff   <= req_data.threshold;
      end
      cur_ff <= cur_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/core/range_and_longest_run_search.sv
// channel   ports                              handshake
// request   start, busy, req_data              taken when start & !busy
// response  rsp_strobe, rsp_data               one cycle per query, no stall
// csr       csr_valid, csr_ready, csr_data     written when csr_valid & csr_ready
//
// L = clog2(MAX_ELEMENTS). A write climbs one tree level per cycle on the single
// memory read port, from the leaf up to the root. A query walks up the tree and
// then down it, each step waiting on one registered memory read. A new request is
// taken only once busy is low again. After reset the block clears all 2 * 2^L tree
// nodes (2048 at the default) with busy high. csr writes are taken at any time.
// The receiver cannot stall results.
module range_and_longest_run_search #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  rars_pkg::req_type            req_data,
   output logic                         rsp_strobe,
   output rars_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rars_pkg::COUNT_W-1:0] csr_data
);
   import rars_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rars_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   rars_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_valid & csr_ready),
      .csr_data (csr_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/core/rars_checker.sv
`include "range_and_longest_run_search_macros.svh"

module rars_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input rars_pkg::rsp_type rsp_data
);

   `RARS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `RARS_ASSERT_IMP(a_rsp_idle, rsp_strobe, !busy && $past(busy), "response outside item end")
   `RARS_ASSERT_NXT(a_rsp_single, rsp_strobe, !rsp_strobe, "response word repeated")
   `RARS_ASSERT_IMP(a_miss_zero, rsp_strobe && !rsp_data.found, rsp_data.end_position == 11'd0, "miss with nonzero end")

endmodule

bind range_and_longest_run_search rars_checker u_rars_checker (.*);

>>> tb/range_and_longest_run_search_test.sv
module range_and_longest_run_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rars_pkg::*;

   localparam int MAX_ELEMENTS = 1024;
   localparam int HOLD_CYCLES  = 64;
   localparam int STALL_LIMIT  = 20000;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 125;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type answer;
   } row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [COUNT_W-1:0] csr_data = '0;

   logic [VALUE_W-1:0] elements [MAX_ELEMENTS];
   logic [COUNT_W-1:0] elem_count;
   rsp_type pending_runs [$];
   row_type rows [$];

   int mismatches;
   int writes_sent;
   int queries_sent;
   int results_seen;
   int hits_seen;
   int counts_written;
   int stall_cycles;

   range_and_longest_run_search #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int in_use();
      return (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elem_count);
   endfunction

   function automatic rsp_type longest_run(logic [INDEX_W-1:0] first,
                                           logic [VALUE_W-1:0] thr);
      int limit;
      logic [VALUE_W-1:0] acc;
      rsp_type run;
      limit = in_use();
      run = '0;
      if (first >= limit || elements[first] < thr)
         return run;
      acc = ALL_ONES;
      run.found = 1'b1;
      run.end_position = COUNT_W'(first);
      for (int e = int'(first); e < limit; e++) begin
         acc &= elements[e];
         if (acc < thr)
            break;
         run.end_position = COUNT_W'(e + 1);
      end
      return run;
   endfunction

   function automatic void add_row(op_type op, int idx, logic [VALUE_W-1:0] v,
                                   logic [VALUE_W-1:0] thr, bit typed, bit f, int e);
      row_type row;
      row.word.op = op;
      row.word.index = INDEX_W'(idx);
      row.word.value = v;
      row.word.threshold = thr;
      row.typed = typed;
      row.answer.found = f;
      row.answer.end_position = COUNT_W'(e);
      rows.push_back(row);
   endfunction

   function automatic req_type random_word();
      req_type word;
      int limit;
      int pick;
      limit = in_use();
      word.op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_QUERY;
      if (limit > 0 && $urandom_range(0, 99) < 85)
         word.index = INDEX_W'($urandom_range(0, limit - 1));
      else
         word.index = INDEX_W'($urandom_range(0, MAX_ELEMENTS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 55)
         word.value = ALL_ONES & ~(VALUE_W'(1) << (($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, VALUE_W - 1) : $urandom_range(0, 7)));
      else if (pick < 70)
         word.value = ALL_ONES;
      else if (pick < 90)
         word.value = VALUE_W'($urandom);
      else
         word.value = '0;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         word.threshold = ALL_ONES - VALUE_W'($urandom_range(0, 300));
      else if (pick < 65)
         word.threshold = elements[word.index];
      else if (pick < 80)
         word.threshold = VALUE_W'($urandom);
      else if (pick < 90)
         word.threshold = '0;
      else
         word.threshold = ALL_ONES;
      return word;
   endfunction

   task automatic issue(req_type word, int gap, bit typed, rsp_type answer);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (busy !== 1'b0);
      if (word.op == OP_WRITE) begin
         elements[word.index] = word.value;
         writes_sent++;
      end else begin
         pending_runs.push_back(typed ? answer : longest_run(word.index, word.threshold));
         queries_sent++;
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending_runs.size() != 0);
   endtask

   task automatic write_count(int n);
      settle();
      repeat (HOLD_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= COUNT_W'(n);
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      elem_count = COUNT_W'(n);
      counts_written++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         results_seen++;
         if (rsp_data.found === 1'b1)
            hits_seen++;
         if (pending_runs.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual found %0b end %0d",
                     $time, rsp_data.found, rsp_data.end_position);
         end else begin
            want = pending_runs.pop_front();
            if (rsp_data.found !== want.found) begin
               mismatches++;
               $display("%0t: found expected %0b actual %0b",
                        $time, want.found, rsp_data.found);
            end
            if (rsp_data.end_position !== want.end_position) begin
               mismatches++;
               $display("%0t: end_position expected %0d actual %0d",
                        $time, want.end_position, rsp_data.end_position);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("range_and_longest_run_search_test failed");
            $finish;
         end
      end
   end

   initial begin
      int phase_counts [PHASES];
      bit burst;
      int gap;
      for (int i = 0; i < MAX_ELEMENTS; i++)
         elements[i] = ALL_ONES;
      elem_count = COUNT_RESET;
      phase_counts = '{1, 2047, 0, 8, 100, 1024, 2, $urandom_range(1, 2047),
                       $urandom_range(1, 2047), 1023};

      add_row(OP_QUERY, 0,    '0,           ALL_ONES,     1, 1, 1024);
      add_row(OP_QUERY, 1023, '0,           ALL_ONES,     1, 1, 1024);
      add_row(OP_QUERY, 0,    '0,           '0,           1, 1, 1024);
      add_row(OP_WRITE, 5,    '0,           '0,           0, 0, 0);
      add_row(OP_QUERY, 0,    '0,           31'd1,        1, 1, 5);
      add_row(OP_QUERY, 5,    '0,           31'd1,        1, 0, 0);
      add_row(OP_QUERY, 5,    '0,           '0,           1, 1, 1024);
      add_row(OP_WRITE, 1023, 31'h7fff_fffe, '0,          0, 0, 0);
      add_row(OP_QUERY, 6,    '0,           ALL_ONES,     1, 1, 1023);
      add_row(OP_QUERY, 1023, '0,           ALL_ONES,     1, 0, 0);
      add_row(OP_WRITE, 0,    31'h5555_5555, '0,          0, 0, 0);
      add_row(OP_WRITE, 1,    31'h2aaa_aaaa, '0,          0, 0, 0);
      add_row(OP_QUERY, 0,    '0,           31'h5555_5555, 1, 1, 1);
      add_row(OP_QUERY, 0,    '0,           '0,           1, 1, 1024);
      add_row(OP_WRITE, 2,    31'h4000_0000, '0,          0, 0, 0);
      add_row(OP_QUERY, 2,    '0,           31'h4000_0000, 1, 1, 5);
      add_row(OP_QUERY, 1,    '0,           31'h2aaa_aaab, 1, 0, 0);
      add_row(OP_WRITE, 1023, ALL_ONES,     '0,           0, 0, 0);
      add_row(OP_QUERY, 6,    '0,           ALL_ONES,     1, 1, 1024);
      add_row(OP_WRITE, 512,  31'h3fff_ffff, '0,          0, 0, 0);
      add_row(OP_QUERY, 100,  '0,           31'h4000_0000, 1, 1, 512);
      add_row(OP_QUERY, 512,  '0,           31'h3fff_ffff, 1, 1, 1024);
      add_row(OP_WRITE, 5,    ALL_ONES,     '0,           0, 0, 0);
      add_row(OP_QUERY, 0,    '0,           ALL_ONES,     0, 0, 0);
      add_row(OP_QUERY, 3,    '0,           31'h7fff_0000, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         issue(rows[i].word, $urandom_range(0, 13), rows[i].typed, rows[i].answer);

      burst = 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         write_count(phase_counts[p]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 29) == 0)
               burst = !burst;
            if (n == 60 && p % 2 == 1)
               settle();
            gap = burst ? 0 : $urandom_range(0, 13);
            issue(random_word(), gap, 1'b0, '0);
         end
      end
      write_count(COUNT_RESET);
      for (int n = 0; n < 20; n++)
         issue(random_word(), $urandom_range(0, 13), 1'b0, '0);

      settle();
      repeat (HOLD_CYCLES) @(posedge clock);
      mismatches += pending_runs.size();
      $display("covered %0d writes and %0d queries over %0d element counts",
               writes_sent, queries_sent, counts_written);
      $display("checked %0d results, %0d of them found a run", results_seen, hits_seen);
      if (mismatches == 0)
         $display("range_and_longest_run_search_test passed");
      else
         $display("range_and_longest_run_search_test failed");
      $finish;
   end

endmodule
